// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the hash counter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define KCH_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every clock edge, reset included.
`define KCH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ----- hw/rtl/kch_pkg.sv -----
// Types and constants of the counting hash table.
package kch_pkg;

    localparam int SLOTS = 1024;
    localparam int SLOT_AW = $clog2(SLOTS);

    localparam int KEY_W = 64;
    localparam int CNT_W = 32;
    localparam int ITEMS_W = 11;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [KEY_W-1:0] EMPTY_KEY = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [ITEMS_W-1:0] LOAD_LIMIT_RESET = 11'd768;

    localparam logic REG_LOAD_LIMIT = 1'b0;

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef logic [1:0] t_status;
    localparam t_status STAT_EXIST = 2'd0;
    localparam t_status STAT_NEW = 2'd1;
    localparam t_status STAT_NOTFOUND = 2'd2;
    localparam t_status STAT_FULL = 2'd3;

    typedef struct packed {
        logic cmd;
        logic [KEY_W-1:0] key;
    } t_in_word;

    typedef struct packed {
        t_status status;
        logic [CNT_W-1:0] count;
        logic [ITEMS_W-1:0] stored_keys;
    } t_out_word;

endpackage

// ----- hw/rtl/kch_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module kch_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/kch_cfg.sv -----
// Configuration register port holding the load limit.
module kch_cfg import kch_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [ITEMS_W-1:0] o_load_limit
);

    logic [ITEMS_W-1:0] r_load_limit;
    logic               wr_limit;

    assign wr_limit = psel && penable && pwrite && (paddr[2] == REG_LOAD_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_limit <= LOAD_LIMIT_RESET;
        end else if (wr_limit) begin
            r_load_limit <= pwdata[ITEMS_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_LOAD_LIMIT) begin
            prdata = {{(PDATA_W-ITEMS_W){1'b0}}, r_load_limit};
        end
    end

    assign pready = 1'b1;
    assign o_load_limit = r_load_limit;

endmodule

// ----- hw/rtl/kch_ctrl.sv -----
// Probe sequencer: clearing pass, slot probing, count update and result register.
`include "assert_macros.svh"

module kch_ctrl import kch_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_word           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_word          o_out_data,
    input  logic [ITEMS_W-1:0] i_load_limit,
    output logic               o_key_we,
    output logic               o_cnt_we,
    output logic [SLOT_AW-1:0] o_waddr,
    output logic [SLOT_AW-1:0] o_raddr,
    output logic [KEY_W-1:0]   o_key_wdata,
    output logic [CNT_W-1:0]   o_cnt_wdata,
    input  logic [KEY_W-1:0]   i_key_rdata,
    input  logic [CNT_W-1:0]   i_cnt_rdata
);

    localparam int AW = SLOT_AW;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_PROBE = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    localparam logic [AW:0] PROBE_MAX = (AW+1)'(SLOTS);
    localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

    function automatic logic [AW-1:0] f_home(input logic [KEY_W-1:0] k);
        logic [AW-1:0] h;
        h = '0;
        for (int b = 0; b < KEY_W; b++) begin
            h[b % AW] = h[b % AW] ^ k[b];
        end
        return h;
    endfunction

    logic [1:0]         r_state, n_state;
    logic [AW-1:0]      r_clr, n_clr;
    logic               r_cmd, n_cmd;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [AW-1:0]      r_slot, n_slot;
    logic [AW:0]        r_step, n_step;
    logic [ITEMS_W-1:0] r_items, n_items;
    t_status            r_status, n_status;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out, n_out;

    logic               hit;
    logic               empty;
    logic [CNT_W-1:0]   cnt_inc;
    logic [AW-1:0]      step_slot;
    logic               out_free;

    assign hit = (i_key_rdata == r_key);
    assign empty = (i_key_rdata == EMPTY_KEY);
    assign cnt_inc = (i_cnt_rdata == CNT_MAX) ? i_cnt_rdata : i_cnt_rdata + 32'd1;
    assign step_slot = r_slot + r_step[AW-1:0];
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        n_clr = r_clr;
        n_cmd = r_cmd;
        n_key = r_key;
        n_slot = r_slot;
        n_step = r_step;
        n_items = r_items;
        n_status = r_status;
        n_count = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        n_out = r_out;
        o_key_we = 1'b0;
        o_cnt_we = 1'b0;
        o_waddr = r_slot;
        o_raddr = f_home(i_in_data.key);
        o_key_wdata = r_key;
        o_cnt_wdata = cnt_inc;
        case (r_state)
            ST_CLEAR: begin
                o_key_we = 1'b1;
                o_cnt_we = 1'b1;
                o_waddr = r_clr;
                o_key_wdata = EMPTY_KEY;
                o_cnt_wdata = '0;
                n_clr = r_clr + AW'(1);
                if (r_clr == LAST_SLOT) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_cmd = i_in_data.cmd;
                    n_key = i_in_data.key;
                    n_slot = f_home(i_in_data.key);
                    n_step = (AW+1)'(1);
                    n_count = '0;
                    if (i_in_data.key == EMPTY_KEY) begin
                        n_status = (i_in_data.cmd == CMD_LOOKUP) ? STAT_NOTFOUND : STAT_FULL;
                        n_state = ST_RESULT;
                    end else begin
                        n_state = ST_PROBE;
                    end
                end
            end
            ST_PROBE: begin
                o_raddr = step_slot;
                n_count = '0;
                if (hit) begin
                    n_status = STAT_EXIST;
                    n_state = ST_RESULT;
                    if (r_cmd == CMD_LOOKUP) begin
                        n_count = i_cnt_rdata;
                    end else begin
                        o_cnt_we = 1'b1;
                        n_count = cnt_inc;
                    end
                end else if (empty) begin
                    n_state = ST_RESULT;
                    if (r_cmd == CMD_LOOKUP) begin
                        n_status = STAT_NOTFOUND;
                    end else if (r_items < i_load_limit) begin
                        o_key_we = 1'b1;
                        o_cnt_we = 1'b1;
                        o_cnt_wdata = 32'd1;
                        n_items = r_items + 11'd1;
                        n_status = STAT_NEW;
                        n_count = 32'd1;
                    end else begin
                        n_status = STAT_FULL;
                    end
                end else if (r_step == PROBE_MAX) begin
                    n_status = (r_cmd == CMD_LOOKUP) ? STAT_NOTFOUND : STAT_FULL;
                    n_state = ST_RESULT;
                end else begin
                    n_slot = step_slot;
                    n_step = r_step + (AW+1)'(1);
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out.status = r_status;
                    n_out.count = r_count;
                    n_out.stored_keys = r_items;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr <= '0;
            r_items <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_items <= n_items;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_key <= n_key;
        r_slot <= n_slot;
        r_step <= n_step;
        r_status <= n_status;
        r_count <= n_count;
        r_out <= n_out;
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

    `KCH_ASSERT(a_items_step, i_clk, i_rst_n,
        (r_items != $past(r_items)) |-> (r_items == $past(r_items) + 11'd1),
        "stored key count moved by other than one")
    `KCH_ASSERT(a_write_in_probe, i_clk, i_rst_n,
        (o_key_we && r_state != ST_CLEAR) |-> (r_state == ST_PROBE && empty && r_cmd == CMD_ADD),
        "key written outside an insert")

endmodule

// ----- hw/rtl/key_count_hash_table.sv -----
// Counting hash table with open addressing and triangular probing over slot key and count RAMs.
// A word accepted in ST_IDLE moves through ST_PROBE, one RAM read per probed slot, then ST_RESULT.
// A new word is taken only in ST_IDLE; ST_RESULT waits while the output is stalled.
// A reserved key skips probing and goes straight to ST_RESULT.
// Reset starts a clearing pass over every slot with o_in_stall high; registers stay writable.
`include "assert_macros.svh"

module key_count_hash_table import kch_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_word           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_word          o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int AW = SLOT_AW;

    logic [ITEMS_W-1:0] load_limit;
    logic               key_we;
    logic               cnt_we;
    logic [AW-1:0]      waddr;
    logic [AW-1:0]      raddr;
    logic [KEY_W-1:0]   key_wdata;
    logic [CNT_W-1:0]   cnt_wdata;
    logic [KEY_W-1:0]   key_rdata;
    logic [CNT_W-1:0]   cnt_rdata;

    kch_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_load_limit (load_limit)
    );

    kch_ram #(
        .WIDTH (KEY_W),
        .DEPTH (SLOTS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (waddr),
        .i_wdata (key_wdata),
        .i_raddr (raddr),
        .o_rdata (key_rdata)
    );

    kch_ram #(
        .WIDTH (CNT_W),
        .DEPTH (SLOTS)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (raddr),
        .o_rdata (cnt_rdata)
    );

    kch_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data),
        .i_load_limit (load_limit),
        .o_key_we     (key_we),
        .o_cnt_we     (cnt_we),
        .o_waddr      (waddr),
        .o_raddr      (raddr),
        .o_key_wdata  (key_wdata),
        .o_cnt_wdata  (cnt_wdata),
        .i_key_rdata  (key_rdata),
        .i_cnt_rdata  (cnt_rdata)
    );

    `KCH_ASSERT(a_new_count_one, i_clk, i_rst_n,
        (o_out_valid && o_out_data.status == STAT_NEW) |-> (o_out_data.count == 32'd1),
        "new key word without a count of one")
    `KCH_ASSERT(a_exist_count_nonzero, i_clk, i_rst_n,
        (o_out_valid && o_out_data.status == STAT_EXIST) |-> (o_out_data.count != 32'd0),
        "existing key word with a zero count")
    `KCH_ASSERT_ALWAYS(a_no_word_after_reset, i_clk,
        $past(!i_rst_n) |-> !o_out_valid,
        "result word valid right after reset")

endmodule
